[sv/door_sequencer_with_timers_defines.svh]
// Assertion macros shared by the door sequencer RTL.
// Each check is clocked and disabled while reset is asserted.
`ifndef DOOR_SEQUENCER_WITH_TIMERS_DEFINES_SVH
`define DOOR_SEQUENCER_WITH_TIMERS_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define DSQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("door sequencer check failed");

// Condition must never be true at a clock edge out of reset.
`define DSQ_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("door sequencer illegal condition");

`else

`define DSQ_ASSERT(label, clk, rst_n, prop)
`define DSQ_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[sv/dsq_pkg.sv]
`timescale 1ns / 1ps

package dsq_pkg;

	// Door phase codes
	localparam logic [2:0] PH_START        = 3'd0;
	localparam logic [2:0] PH_CLOSED       = 3'd1;
	localparam logic [2:0] PH_CLOSED_EXIT  = 3'd2;
	localparam logic [2:0] PH_CLOSING      = 3'd3;
	localparam logic [2:0] PH_CLOSING_EXIT = 3'd4;
	localparam logic [2:0] PH_OPEN_IN      = 3'd5;
	localparam logic [2:0] PH_OPEN_OUT     = 3'd6;
	localparam logic [2:0] PH_UNUSED       = 3'd7;

	// Motor drive codes
	localparam logic [1:0] MOT_STOP  = 2'd0;
	localparam logic [1:0] MOT_OPEN  = 2'd1;
	localparam logic [1:0] MOT_CLOSE = 2'd2;

	// Audio pulse codes
	localparam logic [1:0] AUD_NONE = 2'd0;
	localparam logic [1:0] AUD_PLAY = 2'd1;
	localparam logic [1:0] AUD_STOP = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_INSIDE_HOLD  = 2'd0;
	localparam logic [1:0] CFG_OUTSIDE_HOLD = 2'd1;
	localparam logic [1:0] CFG_PUMP_RUN     = 2'd2;
	localparam logic [1:0] CFG_PUMP_TRIGGER = 2'd3;

	// Configuration reset values
	localparam logic [15:0] INSIDE_HOLD_RST  = 16'd15000;
	localparam logic [15:0] OUTSIDE_HOLD_RST = 16'd7500;
	localparam logic [15:0] PUMP_RUN_RST     = 16'd5000;
	localparam logic [3:0]  PUMP_TRIGGER_RST = 4'd2;

	localparam logic [3:0] EXIT_COUNT_MAX = 4'd15;

	typedef struct packed {
		logic        closed_switch;
		logic        open_switch;
		logic        hand_inside;
		logic        hand_outside;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		logic [1:0] motor_command;
		logic       light_on;
		logic       lock_relays_on;
		logic       pump_on;
		logic [1:0] audio_command;
		logic [2:0] door_phase;
	} out_t;

	typedef struct packed {
		logic [15:0] inside_hold_ms;
		logic [15:0] outside_hold_ms;
		logic [15:0] pump_run_ms;
		logic [3:0]  pump_trigger_count;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [1:0]  motor_level;
		logic        light_level;
		logic        relay_level;
		logic        pump_level;
		logic [31:0] pump_start_time;
		logic        hold_armed;
		logic [31:0] hold_start_time;
		logic [3:0]  exit_close_count;
	} state_t;

endpackage

[sv/dsq_step.sv]
`timescale 1ns / 1ps

module dsq_step (
	input  dsq_pkg::state_t cur,
	input  dsq_pkg::cfg_t   cfg,
	input  dsq_pkg::in_t    tick,
	output dsq_pkg::state_t nxt,
	output dsq_pkg::out_t   res
);
	import dsq_pkg::*;

	// Next state and result for one poll tick; later checks override earlier ones
	always_comb begin
		state_t      n;
		logic [1:0]  audio;
		logic [15:0] hold_ms;
		logic [31:0] hold_elapsed;
		logic [31:0] pump_elapsed;

		n            = cur;
		audio        = AUD_NONE;
		hold_ms      = (cur.phase == PH_OPEN_IN) ? cfg.inside_hold_ms : cfg.outside_hold_ms;
		hold_elapsed = '0;
		pump_elapsed = '0;

		unique case (cur.phase)
			PH_START: begin
				if (tick.closed_switch) begin
					n.motor_level = MOT_STOP;
					n.phase       = PH_CLOSED;
				end else begin
					n.motor_level = MOT_CLOSE;
					n.phase       = PH_CLOSING;
				end
			end
			PH_CLOSED: begin
				if (tick.hand_inside) begin
					n.motor_level = MOT_OPEN;
					n.light_level = 1'b1;
					n.relay_level = 1'b1;
					n.phase       = PH_OPEN_IN;
					n.pump_level  = 1'b0;
					audio         = AUD_PLAY;
				end
				if (tick.hand_outside) begin
					n.motor_level = MOT_OPEN;
					n.light_level = 1'b0;
					n.phase       = PH_OPEN_OUT;
				end
				// pump trigger after enough inside-cut closings
				if (cur.exit_close_count >= cfg.pump_trigger_count) begin
					n.exit_close_count = '0;
					n.pump_level       = 1'b1;
					n.pump_start_time  = tick.now_ms;
				end
				// pump timeout, wrapping elapsed time
				pump_elapsed = tick.now_ms - n.pump_start_time;
				if (n.pump_level && (pump_elapsed >= {16'd0, cfg.pump_run_ms}))
					n.pump_level = 1'b0;
			end
			PH_CLOSED_EXIT: begin
				if (tick.hand_outside) begin
					n.motor_level = MOT_OPEN;
					n.light_level = 1'b0;
					n.phase       = PH_OPEN_OUT;
				end
			end
			PH_CLOSING: begin
				if (tick.closed_switch) begin
					n.motor_level = MOT_STOP;
					n.relay_level = 1'b0;
					n.phase       = PH_CLOSED;
					audio         = AUD_STOP;
				end
			end
			PH_CLOSING_EXIT: begin
				if (tick.closed_switch) begin
					n.motor_level = MOT_STOP;
					n.phase       = PH_CLOSED_EXIT;
				end
			end
			PH_OPEN_IN, PH_OPEN_OUT: begin
				// hold at the open limit, then close
				if (tick.open_switch) begin
					n.motor_level = MOT_STOP;
					if (!cur.hold_armed) begin
						n.hold_start_time = tick.now_ms;
						n.hold_armed      = 1'b1;
					end
					hold_elapsed = tick.now_ms - n.hold_start_time;
					if (hold_elapsed >= {16'd0, hold_ms}) begin
						n.motor_level = MOT_CLOSE;
						n.hold_armed  = 1'b0;
						n.phase       = PH_CLOSING;
						if (cur.phase == PH_OPEN_IN) begin
							n.relay_level = 1'b0;
							audio         = AUD_STOP;
						end
					end
				end
				// exit request cuts the inside opening short
				if ((cur.phase == PH_OPEN_IN) && tick.hand_outside) begin
					n.motor_level = MOT_CLOSE;
					if (cur.exit_close_count < EXIT_COUNT_MAX)
						n.exit_close_count = cur.exit_close_count + 4'd1;
					n.hold_armed = 1'b0;
					n.phase      = PH_CLOSING_EXIT;
				end
			end
			default: begin
				// unused phase code: no action
			end
		endcase

		nxt                = n;
		res.motor_command  = n.motor_level;
		res.light_on       = n.light_level;
		res.lock_relays_on = n.relay_level;
		res.pump_on        = n.pump_level;
		res.audio_command  = audio;
		res.door_phase     = n.phase;
	end

endmodule

[sv/door_sequencer_with_timers.sv]
// An accepted tick moves from the input register through the step into out_data once out_data is free or being taken.
// Throughput: one tick per cycle while the output is not stalled; state feedback is a single registered step per tick.
// The output register lets a new tick enter while a result waits to be taken.
// Reset (arst_n low, asynchronous): start phase, motor, light, relay and pump levels off, out_valid low,
// timers and exit count cleared, configuration back to its default values.
`timescale 1ns / 1ps
`include "door_sequencer_with_timers_defines.svh"

module door_sequencer_with_timers (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  dsq_pkg::in_t    in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output dsq_pkg::out_t   out_data,
	input  logic            cfg_wr_en,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import dsq_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_nxt;
	in_t    tick_s1;
	logic   valid_s1;
	out_t   res_nxt;
	out_t   out_q;
	logic   out_valid_q;
	logic   advance;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inside_hold_ms     <= INSIDE_HOLD_RST;
			cfg_q.outside_hold_ms    <= OUTSIDE_HOLD_RST;
			cfg_q.pump_run_ms        <= PUMP_RUN_RST;
			cfg_q.pump_trigger_count <= PUMP_TRIGGER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_INSIDE_HOLD:  cfg_q.inside_hold_ms     <= cfg_data;
				CFG_OUTSIDE_HOLD: cfg_q.outside_hold_ms    <= cfg_data;
				CFG_PUMP_RUN:     cfg_q.pump_run_ms        <= cfg_data;
				CFG_PUMP_TRIGGER: cfg_q.pump_trigger_count <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves into the output register when that register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			tick_s1 <= in_data;
	end

	dsq_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res_nxt;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	`DSQ_ASSERT(a_stall_needs_item, clk, arst_n, in_stall |-> valid_s1)
	`DSQ_ASSERT(a_advance_fills_out, clk, arst_n, advance |=> out_valid_q)
	`DSQ_ASSERT(a_hold_only_open, clk, arst_n, state_q.hold_armed |-> ((state_q.phase == PH_OPEN_IN) || (state_q.phase == PH_OPEN_OUT)))
	`DSQ_ASSERT_NEVER(a_no_unused_phase, clk, arst_n, state_q.phase == PH_UNUSED)

endmodule
